// ===== sv/scfp_pkg.sv =====
// Shared types and constants for the sync/checksum frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package scfp_pkg;

	localparam logic [7:0] SYNC_FIRST    = 8'h5A;
	localparam logic [7:0] SYNC_SECOND   = 8'hA5;
	localparam int unsigned PAYLOAD_BYTES = 8;
	localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;

	localparam int unsigned PAYLOAD_W = PAYLOAD_BYTES * 8;
	localparam int unsigned CNT_W     = $clog2(PAYLOAD_BYTES);
	localparam logic [CNT_W-1:0] PAYLOAD_LAST = CNT_W'(PAYLOAD_BYTES - 1);
	// both sync bytes already folded into the sum
	localparam logic [7:0] SUM_SEED = 8'(SYNC_FIRST + SYNC_SECOND);

	typedef enum logic [1:0] {
		FR_HUNT,
		FR_SYNC2,
		FR_PAYLOAD,
		FR_CHECK
	} frame_state_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_SUM_ERR    = 2'd1,
		ST_NOT_FINITE = 2'd2
	} frame_status_t;

	typedef struct packed {
		logic                 fire;
		logic                 sum_ok;
		logic [PAYLOAD_W-1:0] payload;
	} frame_end_t;

endpackage

// ===== sv/sync_checksum_frame_parser.sv =====
// A result is registered once the checksum byte has passed the input register (byte_s1).
// Throughput: one byte per cycle; input is held off only when a frame ends
// while the result register is still full and stalled.
// Reset (arst_n, async, active low): hunt state, sum and held command cleared.
// Uses scfp_pkg, scfp_frame_fsm and scfp_cmd_hold.
`timescale 1ns / 1ps
module sync_checksum_frame_parser import scfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  frame_status,
	output logic [31:0] cmd_y_bits,
	output logic [31:0] cmd_z_bits,
	output logic        cmd_present
);

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       go;
	logic       at_check;
	frame_end_t frame_end;

	// only the checksum byte needs room in the result register
	assign go       = vld_s1 && !(at_check && res_valid && res_stall);
	assign rx_stall = vld_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (!rx_stall)
			vld_s1 <= rx_valid;
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall)
			byte_s1 <= rx_byte;
	end

	scfp_frame_fsm u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.byte_s1   (byte_s1),
		.at_check  (at_check),
		.frame_end (frame_end)
	);

	scfp_cmd_hold u_cmd (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_end    (frame_end),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.frame_status (frame_status),
		.cmd_y_bits   (cmd_y_bits),
		.cmd_z_bits   (cmd_z_bits),
		.cmd_present  (cmd_present)
	);

endmodule

// ===== sv/scfp_frame_fsm.sv =====
// Frame tracker: sync hunt, payload shift register and running checksum.
// Depends on scfp_pkg.
`timescale 1ns / 1ps
module scfp_frame_fsm import scfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] byte_s1,
	output logic       at_check,
	output frame_end_t frame_end
);

	frame_state_t         state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [7:0]           sum_q, sum_d;
	logic [PAYLOAD_W-1:0] payload_q;
	logic                 load;

	always_comb begin
		state_d = state_q;
		if (go) begin
			case (state_q)
				FR_HUNT: begin
					if (byte_s1 == SYNC_FIRST)
						state_d = FR_SYNC2;
				end
				FR_SYNC2: begin
					if (byte_s1 == SYNC_SECOND)
						state_d = FR_PAYLOAD;
					else if (byte_s1 != SYNC_FIRST)
						state_d = FR_HUNT;
				end
				FR_PAYLOAD: begin
					if (cnt_q == PAYLOAD_LAST)
						state_d = FR_CHECK;
				end
				FR_CHECK: state_d = FR_HUNT;
				default:  state_d = FR_HUNT;
			endcase
		end
	end

	always_comb begin
		sum_d             = sum_q;
		cnt_d             = cnt_q;
		load              = 1'b0;
		frame_end.fire    = 1'b0;
		frame_end.sum_ok  = (byte_s1 == sum_q);
		frame_end.payload = payload_q;
		if (go) begin
			case (state_q)
				FR_HUNT: sum_d = '0;
				FR_SYNC2: begin
					if (byte_s1 == SYNC_SECOND) begin
						sum_d = SUM_SEED;
						cnt_d = '0;
					end
				end
				FR_PAYLOAD: begin
					sum_d = sum_q + byte_s1;
					cnt_d = cnt_q + 1'b1;
					load  = 1'b1;
				end
				FR_CHECK: begin
					frame_end.fire = 1'b1;
					sum_d          = '0;
				end
				default: sum_d = '0;
			endcase
		end
	end

	assign at_check = (state_q == FR_CHECK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_HUNT;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
		end
	end

	// byte 0 ends up in the low lane after the last shift
	always_ff @(posedge clk) begin
		if (load)
			payload_q <= {byte_s1, payload_q[PAYLOAD_W-1:8]};
	end

endmodule

// ===== sv/scfp_cmd_hold.sv =====
// Frame verdict, held command registers and the result register.
// Depends on scfp_pkg.
`timescale 1ns / 1ps
module scfp_cmd_hold import scfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_end_t  frame_end,
	input  logic        res_stall,
	output logic        res_valid,
	output logic [1:0]  frame_status,
	output logic [31:0] cmd_y_bits,
	output logic [31:0] cmd_z_bits,
	output logic        cmd_present
);

	logic [31:0]   y, z;
	logic          y_fin, z_fin;
	frame_status_t status_d, status_q;
	logic          res_valid_q;
	logic [31:0]   held_y_q, held_z_q;
	logic          held_valid_q;

	assign y     = frame_end.payload[31:0];
	assign z     = frame_end.payload[63:32];
	assign y_fin = (y[30:23] != EXP_ALL_ONES);
	assign z_fin = (z[30:23] != EXP_ALL_ONES);

	always_comb begin
		if (!frame_end.sum_ok)
			status_d = ST_SUM_ERR;
		else if (!y_fin || !z_fin)
			status_d = ST_NOT_FINITE;
		else
			status_d = ST_ACCEPTED;
	end

	// a frame end only fires when the result register is free, so the held
	// command never changes under a stalled result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			status_q     <= ST_ACCEPTED;
			held_y_q     <= '0;
			held_z_q     <= '0;
			held_valid_q <= 1'b0;
		end else begin
			if (frame_end.fire) begin
				res_valid_q <= 1'b1;
				status_q    <= status_d;
				if (status_d == ST_ACCEPTED) begin
					held_y_q     <= y;
					held_z_q     <= z;
					held_valid_q <= 1'b1;
				end
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_status = status_q;
	assign cmd_y_bits   = held_y_q;
	assign cmd_z_bits   = held_z_q;
	assign cmd_present  = held_valid_q;

endmodule

// ===== sv/scfp_checker.sv =====
// Port-level checks for the frame parser, bound to the top level.
// Depends on scfp_pkg and sync_checksum_frame_parser.
`timescale 1ns / 1ps
module scfp_checker import scfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  frame_status,
	input logic        cmd_present
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(frame_status))
		else $error("stalled result transaction changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid && res_stall)
		else $error("input stalled without a blocked result");

	a_present_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(cmd_present))
		else $error("command valid flag dropped");

	a_accept_present: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_status == ST_ACCEPTED |-> cmd_present)
		else $error("accepted frame without command valid flag");

endmodule

bind sync_checksum_frame_parser scfp_checker u_scfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_stall     (rx_stall),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.frame_status (frame_status),
	.cmd_present  (cmd_present)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for sync_checksum_frame_parser: directed and random byte streams,
// an in-bench frame parser predicting each status and held command. Needs scfp_pkg and
// the parser RTL only.
`timescale 1ns / 1ps
module tb_top;
	import scfp_pkg::*;

	localparam int          RX_ITEMS   = 1300;
	localparam int          QUIET_TAIL = 150;   // no idling once this few bytes are left
	localparam int          DRAIN_CYC  = 20;
	localparam int          CYCLE_CAP  = 200000;
	localparam logic [3:0]  POS_HUNT   = 4'd0;
	localparam logic [3:0]  POS_SYNC2  = 4'd1;
	localparam logic [3:0]  POS_DATA0  = 4'd2;
	localparam logic [3:0]  POS_CHECK  = 4'd10;

	typedef struct {
		frame_status_t status;
		logic [31:0]   y;
		logic [31:0]   z;
		logic          present;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [1:0]  frame_status;
	logic [31:0] cmd_y_bits;
	logic [31:0] cmd_z_bits;
	logic        cmd_present;

	logic [7:0]    rx_pending[$];
	frame_result_t results_due[$];

	// predictor state
	logic [3:0]  pos = POS_HUNT;
	logic [63:0] payload = '0;
	logic [7:0]  sum = '0;
	logic [31:0] held_y = '0;
	logic [31:0] held_z = '0;
	logic        held_valid = 1'b0;

	int errors = 0;
	int accepted = 0;
	int cycles = 0;
	int idle_odds = 10;
	int rx_gap = 0;
	int res_gap = 0;
	bit quiet;

	sync_checksum_frame_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.frame_status (frame_status),
		.cmd_y_bits   (cmd_y_bits),
		.cmd_z_bits   (cmd_z_bits),
		.cmd_present  (cmd_present)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit exp_all_ones(input logic [31:0] bits);
		return bits[30:23] == EXP_ALL_ONES;
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b);
		frame_result_t r;
		if (pos == POS_HUNT || pos > POS_CHECK) begin
			pos = (b == SYNC_FIRST) ? POS_SYNC2 : POS_HUNT;
			sum = '0;
		end else if (pos == POS_SYNC2) begin
			if (b == SYNC_SECOND) begin
				pos = POS_DATA0;
				sum = 8'(SYNC_FIRST + SYNC_SECOND);
			end else if (b != SYNC_FIRST) begin
				pos = POS_HUNT;
			end
		end else if (pos < POS_CHECK) begin
			payload[8 * (pos - POS_DATA0) +: 8] = b;
			sum = sum + b;
			pos = pos + 4'd1;
		end else begin
			if (b != sum) begin
				r.status = ST_SUM_ERR;
			end else if (exp_all_ones(payload[31:0]) || exp_all_ones(payload[63:32])) begin
				r.status = ST_NOT_FINITE;
			end else begin
				r.status = ST_ACCEPTED;
				held_y = payload[31:0];
				held_z = payload[63:32];
				held_valid = 1'b1;
			end
			r.y = held_y;
			r.z = held_z;
			r.present = held_valid;
			results_due.push_back(r);
			pos = POS_HUNT;
			sum = '0;
		end
	endtask

	task automatic queue_frame(input logic [31:0] y, input logic [31:0] z, input bit good_sum,
			input int extra_syncs);
		logic [63:0] data;
		logic [7:0]  chk;
		data = {z, y};
		chk = 8'(SYNC_FIRST + SYNC_SECOND);
		repeat (extra_syncs + 1) rx_pending.push_back(SYNC_FIRST);
		rx_pending.push_back(SYNC_SECOND);
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			rx_pending.push_back(data[8 * k +: 8]);
			chk = chk + data[8 * k +: 8];
		end
		if (!good_sum)
			chk = chk + 8'($urandom_range(1, 255));
		rx_pending.push_back(chk);
	endtask

	function automatic logic [31:0] rand_float_bits();
		logic [31:0] bits;
		bits = $urandom;
		case ($urandom_range(0, 7))
			0: bits[30:23] = EXP_ALL_ONES;
			1: bits[30:23] = 8'hFE;
			2: bits[30:23] = 8'h00;
			default: ;
		endcase
		return bits;
	endfunction

	assign quiet = rx_pending.size() < QUIET_TAIL;

	// driver: input side, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte  <= 8'h00;
			rx_gap   <= 0;
		end else if (!rx_valid || !rx_stall) begin
			if (rx_valid) begin
				parse_rx_byte(rx_byte);
				accepted++;
				if (accepted % 100 == 0)
					case ($urandom_range(0, 2))
						0: idle_odds = 0;
						1: idle_odds = 3;
						default: idle_odds = 10;
					endcase
			end
			if (rx_gap > 0) begin
				rx_gap   <= rx_gap - 1;
				rx_valid <= 1'b0;
			end else if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				rx_gap   <= $urandom_range(1, 13) - 1;
				rx_valid <= 1'b0;
			end else if (rx_pending.size() > 0) begin
				rx_valid <= 1'b1;
				rx_byte  <= rx_pending.pop_front();
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// monitor: result side, with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		frame_result_t r;
		if (!arst_n) begin
			res_stall <= 1'b0;
			res_gap   <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result status=%0d y=%h z=%h present=%b", $time,
						frame_status, cmd_y_bits, cmd_z_bits, cmd_present);
					errors++;
				end else begin
					r = results_due.pop_front();
					if (frame_status !== r.status) begin
						$display("%0t: frame_status expected %0d actual %0d", $time,
							r.status, frame_status);
						errors++;
					end
					if (cmd_y_bits !== r.y) begin
						$display("%0t: cmd_y_bits expected %h actual %h", $time, r.y, cmd_y_bits);
						errors++;
					end
					if (cmd_z_bits !== r.z) begin
						$display("%0t: cmd_z_bits expected %h actual %h", $time, r.z, cmd_z_bits);
						errors++;
					end
					if (cmd_present !== r.present) begin
						$display("%0t: cmd_present expected %b actual %b", $time,
							r.present, cmd_present);
						errors++;
					end
				end
			end
			if (res_gap > 0) begin
				res_gap   <= res_gap - 1;
				res_stall <= 1'b1;
			end else if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				res_gap   <= $urandom_range(1, 13) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int pick;
		// stray bytes while hunting, a false start
		rx_pending.push_back(SYNC_SECOND);
		rx_pending.push_back(SYNC_FIRST);
		rx_pending.push_back(8'h00);
		rx_pending.push_back(8'hFF);
		queue_frame(32'h0000_0000, 32'h0000_0000, 1'b1, 0);
		// repeated first sync byte, sync pattern inside the payload
		queue_frame(32'hA55A_A55A, 32'h5AA5_5AA5, 1'b1, 2);
		queue_frame(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1, 0);
		queue_frame(32'h7F80_0000, 32'h3F80_0000, 1'b1, 0);
		queue_frame(32'h3F80_0000, 32'hFFFF_FFFF, 1'b1, 0);
		queue_frame(32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 0);

		while (rx_pending.size() < RX_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				queue_frame(rand_float_bits(), rand_float_bits(), $urandom_range(0, 4) != 0,
					($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 6))
					rx_pending.push_back(($urandom_range(0, 3) == 0) ? SYNC_FIRST :
						8'($urandom));
			end else if (pick < 95) begin
				// broken sync: first byte then anything
				rx_pending.push_back(SYNC_FIRST);
				rx_pending.push_back(8'($urandom));
			end else begin
				rx_pending.push_back(($urandom_range(0, 1) == 0) ? SYNC_FIRST : SYNC_SECOND);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_pending.size() > 0 || rx_valid) @(posedge clk);
		while (results_due.size() > 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (errors == 0 && results_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/scfp_pkg.sv
sv/scfp_frame_fsm.sv
sv/scfp_cmd_hold.sv
sv/sync_checksum_frame_parser.sv
sv/scfp_checker.sv
bench/tb_top.sv
